// ===== rtl/call_syntax_command_parser_core_defines.svh =====
// Shared assertion macros for the command parser core.
`ifndef CALL_SYNTAX_COMMAND_PARSER_CORE_DEFINES_SVH
`define CALL_SYNTAX_COMMAND_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csp: next-cycle check failed");

`endif

// ===== rtl/csp_pkg.sv =====
package csp_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_COMPLETE = 2'd1;
   localparam logic [1:0] EV_FAILED   = 2'd2;

   localparam logic TGT_NAME = 1'b0;
   localparam logic TGT_ARG  = 1'b1;

   localparam int unsigned RSP_DATA_W = 32;

   // Classified request as it travels from the front end to the back end.
   typedef struct packed {
      logic [7:0] char_val;
      logic       is_nul;
      logic       is_lparen;
      logic       is_rparen;
      logic       is_comma;
      logic       is_quote;
      logic       is_blank;  // space or tab
      logic       is_ws;     // space, tab, CR or LF
   } cls_type;

endpackage

// ===== rtl/csp_front.sv =====
module csp_front
   import csp_pkg::*;
(
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       queue_full,
   output logic       push,
   output cls_type    push_cls
);

   logic [7:0] c;

   assign c          = req_tdata;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_cls.char_val  = c;
      push_cls.is_nul    = (c == CH_NUL);
      push_cls.is_lparen = (c == CH_LPAREN);
      push_cls.is_rparen = (c == CH_RPAREN);
      push_cls.is_comma  = (c == CH_COMMA);
      push_cls.is_quote  = (c == CH_QUOTE);
      push_cls.is_blank  = (c == CH_SPACE) || (c == CH_TAB);
      push_cls.is_ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   end

endmodule

// ===== rtl/csp_queue.sv =====
module csp_queue
   import csp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_cls,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cls_type head_cls
);

   cls_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_cls  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/csp_back.sv =====
`include "call_syntax_command_parser_core_defines.svh"
module csp_back
   import csp_pkg::*;
#(
   parameter int unsigned FIELD_LEN = 32,
   parameter int unsigned ARG_LIMIT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  cls_type               head_cls,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned OFF_W = $clog2(FIELD_LEN + 1);
   localparam int unsigned ARG_W = $clog2(ARG_LIMIT + 2);

   localparam logic [2:0] PH_COMMAND = 3'd0;
   localparam logic [2:0] PH_ARGS    = 3'd1;
   localparam logic [2:0] PH_STRING  = 3'd2;
   localparam logic [2:0] PH_ERROR   = 3'd3;
   localparam logic [2:0] PH_END     = 3'd4;

   logic [2:0]       phase_ff, phase_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [ARG_W-1:0] arg_ff, arg_in;
   logic             fae_ff, fae_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [24:0]      rsp_data_ff, rsp_data_in;

   logic             fire;
   logic [2:0]       ph;
   logic [OFF_W-1:0] off;
   logic [ARG_W:0]   arg_inc;
   logic             wv, wt;
   logic [3:0]       wslot;
   logic [4:0]       wpos;
   logic [7:0]       wch;
   logic [1:0]       ev;
   logic [3:0]       total;
   logic             fae_new;
   logic             rsp_has_event;
   logic             rsp_is_term;

   assign fire = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = fire;

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      arg_in    = arg_ff;
      wv        = 1'b0;
      wt        = TGT_NAME;
      wslot     = '0;
      wpos      = '0;
      wch       = '0;
      ev        = EV_NONE;
      total     = '0;
      arg_inc   = (ARG_W + 1)'(arg_ff) + 1'b1;
      fae_new   = fae_ff;
      ph        = phase_ff;
      off       = offset_ff;

      if (!head_cls.is_nul) begin
         // A full field turns this byte into an error-phase byte.
         if (offset_ff >= OFF_W'(FIELD_LEN)) begin
            ph  = PH_ERROR;
            off = '0;
         end
         phase_in  = ph;
         offset_in = off;

         unique case (ph)
            PH_COMMAND: begin
               wv    = 1'b1;
               wpos  = 5'(off);
               if (head_cls.is_lparen) begin
                  offset_in = '0;
                  arg_in    = '0;
                  phase_in  = PH_ARGS;
               end else begin
                  wch       = head_cls.char_val;
                  offset_in = OFF_W'(off + 1'b1);
               end
            end
            PH_ARGS: begin
               priority if (head_cls.is_comma) begin
                  wv        = 1'b1;
                  wt        = TGT_ARG;
                  wslot     = 4'(arg_ff);
                  wpos      = 5'(off);
                  offset_in = '0;
                  arg_in    = ARG_W'(arg_inc);
                  if (arg_inc > (ARG_W + 1)'(ARG_LIMIT)) begin
                     phase_in = PH_ERROR;
                  end
               end else if (head_cls.is_rparen) begin
                  wv        = 1'b1;
                  wt        = TGT_ARG;
                  wslot     = 4'(arg_ff);
                  wpos      = 5'(off);
                  offset_in = OFF_W'(off + 1'b1);
                  phase_in  = PH_END;
                  ev        = EV_COMPLETE;
               end else if (head_cls.is_quote) begin
                  phase_in = PH_STRING;
               end else if (!head_cls.is_blank) begin
                  wv        = 1'b1;
                  wt        = TGT_ARG;
                  wslot     = 4'(arg_ff);
                  wpos      = 5'(off);
                  wch       = head_cls.char_val;
                  offset_in = OFF_W'(off + 1'b1);
               end else begin
                  phase_in = ph;
               end
            end
            PH_STRING: begin
               if (head_cls.is_quote) begin
                  phase_in = PH_ARGS;
               end else begin
                  wv        = 1'b1;
                  wt        = TGT_ARG;
                  wslot     = 4'(arg_ff);
                  wpos      = 5'(off);
                  wch       = head_cls.char_val;
                  offset_in = OFF_W'(off + 1'b1);
               end
            end
            PH_ERROR: begin
               if (head_cls.is_rparen) begin
                  arg_in   = '0;
                  wv       = 1'b1;
                  phase_in = PH_END;
                  ev       = EV_FAILED;
               end
            end
            default: begin
               // End phase, and the unused codes behave the same.
               if (!head_cls.is_ws) begin
                  phase_in  = PH_COMMAND;
                  offset_in = OFF_W'(1);
                  wv        = 1'b1;
                  wch       = head_cls.char_val;
               end
            end
         endcase

         // Track whether slot 0 opened with a terminator; use the full slot
         // and offset, not the truncated response fields.
         if (wv && wt == TGT_ARG && arg_ff == '0 && off == '0) begin
            fae_new = (wch == 8'h00);
         end

         if (ev == EV_COMPLETE) begin
            arg_in = fae_new ? '0 : ARG_W'(arg_inc);
            total  = 4'(arg_in);
         end
      end

      fae_in = fae_new;
      rsp_data_in = {total, ev, wch, wpos, wslot, wt, wv};
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COMMAND;
         offset_ff    <= '0;
         arg_ff       <= '0;
         fae_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff  <= phase_in;
            offset_ff <= offset_in;
            arg_ff    <= arg_in;
            fae_ff    <= fae_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 25){1'b0}}, rsp_data_ff};

   assign rsp_has_event = rsp_valid_ff && (rsp_data_ff[20:19] != EV_NONE);
   assign rsp_is_term   = rsp_data_ff[0] && (rsp_data_ff[18:11] == 8'h00);

   `CSP_ASSERT_IMPLY(a_event_writes_term, clock, reset, rsp_has_event, rsp_is_term)
   `CSP_ASSERT_IMPLY(a_offset_bound, clock, reset, 1'b1, offset_ff <= OFF_W'(FIELD_LEN))
   `CSP_ASSERT_IMPLY(a_arg_bound, clock, reset, 1'b1, arg_ff <= ARG_W'(ARG_LIMIT + 1))
   `CSP_ASSERT_NEXT(a_event_ends, clock, reset, fire && ev != EV_NONE, phase_ff == PH_END)

endmodule

// ===== rtl/call_syntax_command_parser_core.sv =====
// Channel     | Dir | Ports                     | Payload
// ------------+-----+---------------------------+----------------------------------------
// request     | in  | req_tvalid/tready/tdata   | one text byte
// response    | out | rsp_tvalid/tready/tdata   | buffer write, event, argument count
//
// Throughput is one byte per cycle while the response side is not stalled: the
// back end updates the parse state and loads the response register per request.
// With the queue empty, an accepted request is written into the queue and from
// there into the response register, whose valid flag drives rsp_tvalid.
// Reset is synchronous and active high; it empties the queue and returns the
// parser to the command phase with offset, slot and flags at zero.
// A stall on the response side holds the back end; the four-entry queue keeps
// absorbing requests until it fills, then req_tready drops.
module call_syntax_command_parser_core
   import csp_pkg::*;
#(
   parameter int unsigned FIELD_LEN = 32,
   parameter int unsigned ARG_LIMIT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] char_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] write_valid, [1] write_target, [5:2] write_slot, [10:6] write_pos,
   // [18:11] write_char, [20:19] event_res, [24:21] arg_total, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cls_type push_cls;
   cls_type head_cls;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_not_empty;

   // Front end: accept and classify each byte.
   csp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cls   (push_cls)
   );

   // Short queue decoupling the two sides.
   csp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cls  (push_cls),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cls  (head_cls)
   );

   // Back end: advance the parse state and register the response.
   csp_back #(
      .FIELD_LEN (FIELD_LEN),
      .ARG_LIMIT (ARG_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_cls   (head_cls),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
